>>> src/bbs_pkg.sv
// shared constants and types for the bounding box and sphere block
`timescale 1ns / 1ps
package bbs_pkg;

  // coordinate width, signed fixed point
  localparam int COORD_BITS = 16;
  // squared distance width; three squares of a full-scale value fit here
  localparam int DIST_BITS  = 2 * COORD_BITS;
  // width of the positive box bounds on the result side
  localparam int MAX_BITS   = COORD_BITS - 1;
  // bit counter width for the serial units
  localparam int CNT_W      = $clog2(COORD_BITS);
  // number of axes
  localparam int AXES       = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [DIST_BITS-1:0]         dist_t;

  // top-level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_PUT  = 4'b1000
  } bbs_state_t;

endpackage

>>> src/bbs_sqmag.sv
// bit-serial squared distance: x*x + y*y + z*z by shift and add
`timescale 1ns / 1ps
module bbs_sqmag import bbs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  coord_t coord_x,
  input  coord_t coord_y,
  input  coord_t coord_z,
  output logic   done,
  output dist_t  dist_sq
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [1:0]       axis_r, axis_nxt;
  dist_t            mcand_r, mcand_nxt;
  mag_t             mplier_r, mplier_nxt;
  mag_t             next_y_r, next_y_nxt;
  mag_t             next_z_r, next_z_nxt;
  dist_t            acc_r, acc_nxt;

  mag_t mag_x, mag_y, mag_z;

  // magnitudes; the most negative value maps to the top power of two
  assign mag_x = coord_x[COORD_BITS-1] ? mag_t'(~coord_x + 1'b1) : mag_t'(coord_x);
  assign mag_y = coord_y[COORD_BITS-1] ? mag_t'(~coord_y + 1'b1) : mag_t'(coord_y);
  assign mag_z = coord_z[COORD_BITS-1] ? mag_t'(~coord_z + 1'b1) : mag_t'(coord_z);

  // one multiplier bit per cycle, axes one after another
  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    bit_cnt_nxt = bit_cnt_r;
    axis_nxt    = axis_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    next_y_nxt  = next_y_r;
    next_z_nxt  = next_z_r;
    acc_nxt     = acc_r;
    if (start) begin
      busy_nxt    = 1'b1;
      bit_cnt_nxt = '0;
      axis_nxt    = '0;
      mcand_nxt   = dist_t'(mag_x);
      mplier_nxt  = mag_x;
      next_y_nxt  = mag_y;
      next_z_nxt  = mag_z;
      acc_nxt     = '0;
    end else if (busy_r) begin
      acc_nxt     = acc_r + (mplier_r[0] ? mcand_r : '0);
      mplier_nxt  = mplier_r >> 1;
      mcand_nxt   = mcand_r << 1;
      bit_cnt_nxt = bit_cnt_r + 1'b1;
      if (bit_cnt_r == CNT_W'(COORD_BITS - 1)) begin
        bit_cnt_nxt = '0;
        if (axis_r == 2'd2) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          // move on to the next axis
          axis_nxt   = axis_r + 1'b1;
          mcand_nxt  = dist_t'(next_y_r);
          mplier_nxt = next_y_r;
          next_y_nxt = next_z_r;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    bit_cnt_r <= bit_cnt_nxt;
    axis_r    <= axis_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    next_y_r  <= next_y_nxt;
    next_z_r  <= next_z_nxt;
    acc_r     <= acc_nxt;
  end

  assign done    = done_r;
  assign dist_sq = acc_r;

endmodule

>>> src/bbs_isqrt.sv
// digit-serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module bbs_isqrt import bbs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  dist_t radicand,
  output logic  done,
  output mag_t  root
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  dist_t                 rad_r, rad_nxt;
  // remainder stays at most twice the partial root, so it fits until the last step
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  mag_t                  root_r, root_nxt;

  logic [COORD_BITS+1:0] rem_sh;
  logic [COORD_BITS+1:0] trial;
  logic                  fits;

  // bring in the next two radicand bits and try a one in the root
  assign rem_sh = {rem_r, rad_r[DIST_BITS-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = fits ? (rem_sh[COORD_BITS-1:0] - trial[COORD_BITS-1:0])
                      : rem_sh[COORD_BITS-1:0];
      root_nxt = {root_r[COORD_BITS-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(COORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> src/bounding_box_and_sphere.sv
// top level: running bounding box and bounding sphere of a vertex stream
//
// Vertices arrive on the in_ channel as signed Q8.8 x, y, z with a last
// flag. A transfer happens on a rising edge with valid high and stall low.
// Each vertex updates the per-axis minima and maxima (which start at zero)
// and, through a bit-serial shift-and-add unit, its squared distance.
// The input is stalled until that distance is done, so a new vertex is
// not taken before the last one is through.
// On a vertex marked last, a digit-serial square root then runs on the
// largest squared distance, and the radius and six box bounds are put in
// the output register once the output slot is free or draining; the next
// vertex can follow in the cycle after. The running state then clears
// for the next model.
// The output register lets the next vertex be taken while a result waits
// on a stalled out_ channel; a further result waits until it drains.
// Reset (rst_n low, synchronous) clears the bounds, the distance, the
// sequencer and the output valid flag.
`timescale 1ns / 1ps
module bounding_box_and_sphere import bbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic                  in_last_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_radius,
  output logic signed [COORD_BITS-1:0] out_min_x,
  output logic signed [COORD_BITS-1:0] out_min_y,
  output logic signed [COORD_BITS-1:0] out_min_z,
  output logic [MAX_BITS-1:0]   out_max_x,
  output logic [MAX_BITS-1:0]   out_max_y,
  output logic [MAX_BITS-1:0]   out_max_z
);

  bbs_state_t state_r, state_nxt;
  logic       last_r, last_nxt;
  dist_t      largest_r, largest_nxt;
  coord_t     low_r  [AXES];
  coord_t     low_nxt [AXES];
  coord_t     high_r [AXES];
  coord_t     high_nxt [AXES];
  logic       out_valid_r, out_valid_nxt;
  mag_t       out_radius_r, out_radius_nxt;
  coord_t     out_min_r [AXES];
  coord_t     out_min_nxt [AXES];
  coord_t     out_max_r [AXES];
  coord_t     out_max_nxt [AXES];

  logic   in_xfer;
  logic   sq_done;
  dist_t  sq_dist;
  dist_t  best_dist;
  logic   root_start;
  logic   root_done;
  mag_t   root_val;
  coord_t in_c [AXES];
  logic   put_ok;

  assign in_c[0] = in_coord_x;
  assign in_c[1] = in_coord_y;
  assign in_c[2] = in_coord_z;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // squared distance of the vertex just taken
  bbs_sqmag u_sqmag (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .coord_z (in_coord_z),
    .done    (sq_done),
    .dist_sq (sq_dist)
  );

  // largest distance including the vertex just finished
  assign best_dist  = (sq_dist > largest_r) ? sq_dist : largest_r;
  assign root_start = (state_r == ST_SQ) && sq_done && last_r;

  bbs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (best_dist),
    .done     (root_done),
    .root     (root_val)
  );

  // output slot free or draining this cycle
  assign put_ok = !out_valid_r || !out_stall;

  // sequencer and running state
  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    largest_nxt    = largest_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    out_radius_nxt = out_radius_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          last_nxt  = in_last_vertex;
          state_nxt = ST_SQ;
          for (int i = 0; i < AXES; i++) begin
            if (in_c[i] > high_r[i]) begin
              high_nxt[i] = in_c[i];
            end else if (in_c[i] < low_r[i]) begin
              low_nxt[i] = in_c[i];
            end
          end
        end
      end
      ST_SQ: begin
        if (sq_done) begin
          largest_nxt = best_dist;
          state_nxt   = last_r ? ST_ROOT : ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put_ok) begin
          out_valid_nxt  = 1'b1;
          out_radius_nxt = root_val;
          out_min_nxt    = low_r;
          out_max_nxt    = high_r;
          // clear for the next model
          largest_nxt    = '0;
          for (int i = 0; i < AXES; i++) begin
            low_nxt[i]  = '0;
            high_nxt[i] = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      largest_r   <= '0;
      for (int i = 0; i < AXES; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      largest_r   <= largest_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    out_radius_r <= out_radius_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_radius = out_radius_r;
  assign out_min_x  = out_min_r[0];
  assign out_min_y  = out_min_r[1];
  assign out_min_z  = out_min_r[2];
  assign out_max_x  = out_max_r[0][MAX_BITS-1:0];
  assign out_max_y  = out_max_r[1][MAX_BITS-1:0];
  assign out_max_z  = out_max_r[2][MAX_BITS-1:0];

endmodule
